// ===== sv/lkvc_pkg.sv =====
// shared types and constants for the lru key-value cache
// no dependencies; imported by lru_key_value_cache
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > OCC_W) ? CAP_W : OCC_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } req_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } rsp_item_t;

endpackage

// ===== sv/lru_key_value_cache.sv =====
// lru key-value cache top level: request register, parallel key match,
// age update and response register; depends on lkvc_pkg
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  lkvc_pkg::req_item_t
//  rsp       out        rsp_valid / rsp_stall  lkvc_pkg::rsp_item_t
//  cfg       in         cfg_we                 cfg_wdata (active_capacity)
//
// one transaction per cycle sustained while the response side does not stall;
// a request passes through the request register, then the response register
// the whole lookup, age rank update and replacement are combinational:
// every entry compares its key in parallel and the victim is the entry
// whose age equals occupancy minus one
// reset clears valid marks, ages and occupancy and sets capacity to 16
// a stalled response holds the response register and any pending request and raises req_stall
module lru_key_value_cache (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  lkvc_pkg::req_item_t          req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output lkvc_pkg::rsp_item_t          rsp,
    input  logic                         cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]   cfg_wdata
);
    import lkvc_pkg::*;

    logic                    req_valid_reg;
    req_item_t               req_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_reg;
    rsp_item_t               rsp_next;
    logic [CAP_W-1:0]        cap_reg;
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        occ_next;
    logic [ENTRIES-1:0]      valid_reg;
    logic [ENTRIES-1:0]      valid_next;
    logic [AGE_W-1:0]        age_reg   [ENTRIES];
    logic [AGE_W-1:0]        age_next  [ENTRIES];
    logic signed [31:0]      key_reg   [ENTRIES];
    logic signed [31:0]      val_reg   [ENTRIES];
    logic [ENTRIES-1:0]      write_sel;

    logic                    advance;
    logic                    do_item;
    logic [ENTRIES-1:0]      match;
    logic [ENTRIES-1:0]      victim;
    logic [ENTRIES-1:0]      free_sel;
    logic                    found;
    logic                    full;
    logic                    evict_sel;
    logic                    insert_sel;
    logic [AGE_W-1:0]        hit_age;
    logic [AGE_W-1:0]        victim_age;
    logic signed [31:0]      hit_value;
    logic signed [31:0]      victim_key;
    logic [CMP_W-1:0]        eff_cap;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign do_item   = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = CMP_W'(cap_reg);
    end

    assign victim_age = AGE_W'(occ_reg - OCC_W'(1));
    assign full       = (CMP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);

    always_comb
    begin
        hit_age    = '0;
        hit_value  = '0;
        victim_key = '0;
        free_sel   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == req_reg.lookup_key);
            victim[i] = valid_reg[i] && (age_reg[i] == victim_age);
            hit_age    = hit_age    | (match[i]  ? age_reg[i] : '0);
            hit_value  = hit_value  | (match[i]  ? val_reg[i] : '0);
            victim_key = victim_key | (victim[i] ? key_reg[i] : '0);
        end
        // lowest free slot
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_sel = ENTRIES'(1) << i;
        end
    end

    assign found      = |match;
    assign evict_sel  = !found && (req_reg.operation == OP_PUT) && full;
    assign insert_sel = !found && (req_reg.operation == OP_PUT) && !full;

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        write_sel  = '0;
        for (int i = 0; i < ENTRIES; i++)
            age_next[i] = age_reg[i];

        if (found)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match[i])
                    age_next[i] = '0;
                else if (valid_reg[i] && age_reg[i] < hit_age)
                    age_next[i] = age_reg[i] + AGE_W'(1);
            end
            if (req_reg.operation == OP_PUT)
                write_sel = match;
        end
        else if (evict_sel)
        begin
            // victim slot is reused, everyone younger ages by one
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (victim[i])
                    age_next[i] = '0;
                else if (valid_reg[i] && age_reg[i] < victim_age)
                    age_next[i] = age_reg[i] + AGE_W'(1);
            end
            write_sel = victim;
        end
        else if (insert_sel)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (free_sel[i])
                    age_next[i] = '0;
                else if (valid_reg[i])
                    age_next[i] = age_reg[i] + AGE_W'(1);
            end
            valid_next = valid_reg | free_sel;
            occ_next   = occ_reg + OCC_W'(1);
            write_sel  = free_sel;
        end

        rsp_next.hit         = found;
        rsp_next.read_value  = (found && req_reg.operation == OP_GET) ? hit_value : MISS_VALUE;
        rsp_next.evicted     = evict_sel;
        rsp_next.evicted_key = evict_sel ? victim_key : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            valid_reg     <= '0;
            for (int i = 0; i < ENTRIES; i++)
                age_reg[i] <= '0;
        end
        else
        begin
            if (!req_valid_reg || advance)
                req_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= req_valid_reg;
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (do_item)
            begin
                occ_reg   <= occ_next;
                valid_reg <= valid_next;
                for (int i = 0; i < ENTRIES; i++)
                    age_reg[i] <= age_next[i];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!req_valid_reg || advance)
            req_reg <= req;
        if (do_item)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (write_sel[i])
                begin
                    key_reg[i] <= req_reg.lookup_key;
                    val_reg[i] <= req_reg.write_value;
                end
            end
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(ENTRIES))
        else $error("occupancy above entry count");

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy differs from number of valid entries");

    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.evicted && rsp_reg.hit))
        else $error("response reports both hit and eviction");

    a_evict_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (do_item && evict_sel) |=> $stable(occ_reg) && $stable(valid_reg))
        else $error("eviction changed occupancy");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_item && insert_sel) |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("insert did not grow occupancy");

endmodule

// ===== verif/tb_lru_key_value_cache.sv =====
// self-checking testbench for lru_key_value_cache: directed and random get/put traffic
// with random pacing on both channels, checked against an in-bench lru predictor
// depends on lkvc_pkg and lru_key_value_cache
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_item_t  req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_item_t  rsp;
    logic       cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    lru_key_value_cache dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // predictor state
    logic signed [31:0] line_key [ENTRIES];
    logic signed [31:0] line_val [ENTRIES];
    bit                 line_vld [ENTRIES];
    int unsigned        line_age [ENTRIES];
    int unsigned        line_occ;
    logic [CAP_W-1:0]   line_cap;

    rsp_item_t          predicted_rsp [$];
    int unsigned        fault_count;
    int unsigned        report_count;

    // shared stimulus controls
    bit                 pacing;
    int unsigned        rsp_hold_len;
    int unsigned        rsp_hold_seq;
    logic signed [31:0] key_pool [32];
    int unsigned        pool_len;

    function automatic int unsigned gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // make slot s the most recent entry
    function automatic void promote_line(int s);
        int unsigned a;
        a = line_age[s];
        for (int i = 0; i < ENTRIES; i++)
            if (line_vld[i] && line_age[i] < a)
                line_age[i]++;
        line_age[s] = 0;
    endfunction

    function automatic rsp_item_t predict_access(req_item_t r);
        rsp_item_t   res;
        int          found;
        int          slot;
        int unsigned cap_eff;
        int unsigned oldest;
        found = -1;
        slot = -1;
        oldest = 0;
        res.hit = 1'b0;
        res.read_value = MISS_VALUE;
        res.evicted = 1'b0;
        res.evicted_key = '0;
        cap_eff = (line_cap == 0) ? 1 : (line_cap > ENTRIES) ? ENTRIES : line_cap;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && line_vld[i] && line_key[i] == r.lookup_key)
                found = i;
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (r.operation == OP_PUT)
                line_val[found] = r.write_value;
            else
                res.read_value = line_val[found];
            promote_line(found);
        end
        else if (r.operation == OP_PUT)
        begin
            if (line_occ >= cap_eff && line_occ > 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (line_vld[i] && (slot < 0 || line_age[i] > oldest))
                    begin
                        slot = i;
                        oldest = line_age[i];
                    end
                res.evicted = 1'b1;
                res.evicted_key = line_key[slot];
                promote_line(slot);
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !line_vld[i])
                        slot = i;
                for (int i = 0; i < ENTRIES; i++)
                    if (line_vld[i])
                        line_age[i]++;
                line_vld[slot] = 1'b1;
                line_age[slot] = 0;
                line_occ++;
            end
            line_key[slot] = r.lookup_key;
            line_val[slot] = r.write_value;
        end
        return res;
    endfunction

    // every call starts right after a rising edge
    task automatic send_item(input logic op, input logic signed [31:0] key,
                             input logic signed [31:0] val);
        req_item_t item;
        item.operation = op;
        item.lookup_key = key;
        item.write_value = val;
        req <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        predicted_rsp.push_back(predict_access(item));
    endtask

    task automatic idle_req(input int unsigned n);
        req_item_t filler;
        filler.operation = 1'($urandom_range(0, 1));
        filler.lookup_key = $urandom();
        filler.write_value = $urandom();
        req_valid <= 1'b0;
        req <= filler;
        repeat (n) @(posedge clk);
    endtask

    task automatic pace_req();
        if (pacing && $urandom_range(0, 3) == 0)
            idle_req(gap_len());
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (predicted_rsp.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        line_cap = v;
    endtask

    function automatic void fill_pool(int unsigned n);
        logic signed [31:0] corners [4];
        corners = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0};
        pool_len = n;
        for (int i = 0; i < n; i++)
            key_pool[i] = ($urandom_range(0, 9) == 0) ? corners[$urandom_range(0, 3)]
                                                      : $urandom();
    endfunction

    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, pool_len - 1)];
        return $urandom();
    endfunction

    task automatic send_random();
        send_item($urandom_range(0, 1) ? OP_PUT : OP_GET, pick_key(), $urandom());
    endtask

    task automatic test_basic_access();
        pacing = 1'b0;
        send_item(OP_GET, 32'sd0, 32'sd0);
        send_item(OP_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
        send_item(OP_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(OP_PUT, -32'sd1, 32'sd0);
        send_item(OP_PUT, 32'sd0, -32'sd1);
        send_item(OP_GET, 32'sh8000_0000, 32'sh5555_5555);
        send_item(OP_GET, 32'sh7fff_ffff, 32'shaaaa_aaaa);
        send_item(OP_GET, -32'sd1, 32'sd0);
        send_item(OP_GET, 32'sd0, -32'sd1);
        send_item(OP_PUT, 32'sh7fff_ffff, 32'sh5a5a_5a5a);
        send_item(OP_GET, 32'sh7fff_ffff, 32'sd0);
        send_item(OP_GET, 32'sd12345, 32'sd0);
    endtask

    // capacity zero acts as one and sits below current occupancy
    task automatic test_capacity_floor();
        pacing = 1'b0;
        write_capacity(5'd0);
        send_item(OP_PUT, 32'sd77, 32'sd1);
        send_item(OP_PUT, 32'sd88, 32'sd2);
        send_item(OP_GET, 32'sd77, 32'sd0);
        send_item(OP_GET, 32'sd88, 32'sd0);
        send_item(OP_GET, 32'sh8000_0000, 32'sd0);
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] caps [7];
        logic [CAP_W-1:0] cap;
        int unsigned      eff;
        int unsigned      pool_n;
        caps = '{5'd31, 5'd2, 5'd16, 5'd1, 5'd9, 5'd0, 5'd5};
        for (int ph = 0; ph < 8; ph++)
        begin
            cap = (ph < 7) ? caps[ph] : CAP_W'($urandom_range(0, 31));
            write_capacity(cap);
            eff = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
            pool_n = eff + $urandom_range(1, eff + 2);
            if (pool_n > 32)
                pool_n = 32;
            fill_pool(pool_n);
            pacing = (ph != 3);
            repeat (65)
            begin
                send_random();
                pace_req();
            end
        end
    endtask

    // receiver holds off long enough that the block fills and stalls its input
    task automatic test_full_backpressure();
        write_capacity(5'd8);
        fill_pool(12);
        pacing = 1'b0;
        rsp_hold_len = 60;
        rsp_hold_seq++;
        repeat (40)
            send_random();
    endtask

    task automatic test_sender_pause();
        pacing = 1'b1;
        repeat (20)
        begin
            send_random();
            pace_req();
        end
        wait_drained();
        repeat (20)
        begin
            send_random();
            pace_req();
        end
    endtask

    // response pacing and the long hold-off
    initial
    begin : rsp_pacing
        int unsigned hold_left;
        int unsigned run_left;
        int unsigned hold_seen;
        hold_left = 0;
        run_left = 0;
        hold_seen = 0;
        rsp_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_hold_seq != hold_seen)
            begin
                hold_left = rsp_hold_len;
                hold_seen = rsp_hold_seq;
            end
            if (hold_left != 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (run_left != 0)
            begin
                rsp_stall <= 1'b1;
                run_left--;
            end
            else if (pacing && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                run_left = gap_len() - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_rsp.size() == 0)
            begin
                fault_count++;
                if (report_count < 10)
                    $display("unexpected transaction: hit=%0b rd=%0d ev=%0b evk=%0d",
                             rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
                report_count++;
            end
            else
            begin
                want = predicted_rsp.pop_front();
                if (rsp.hit !== want.hit || rsp.read_value !== want.read_value ||
                    rsp.evicted !== want.evicted || rsp.evicted_key !== want.evicted_key)
                begin
                    fault_count++;
                    if (report_count < 10)
                    begin
                        $display("mismatch: exp hit=%0b rd=%0d ev=%0b evk=%0d",
                                 want.hit, want.read_value, want.evicted, want.evicted_key);
                        $display("          got hit=%0b rd=%0d ev=%0b evk=%0d",
                                 rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
                    end
                    report_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned waited;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pacing = 1'b0;
        rsp_hold_len = 0;
        rsp_hold_seq = 0;
        pool_len = 1;
        key_pool[0] = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_key[i] = '0;
            line_val[i] = '0;
            line_vld[i] = 1'b0;
            line_age[i] = 0;
        end
        line_occ = 0;
        line_cap = CAP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_access();
        test_capacity_floor();
        test_random_traffic();
        test_full_backpressure();
        test_sender_pause();

        pacing = 1'b0;
        req_valid <= 1'b0;
        waited = 0;
        while (predicted_rsp.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (fault_count == 0 && predicted_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (400000) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
